[rtl/core/lcdf_pkg.sv]
// Shared types, codes and constants for the serial LCD cursor framer.
// Used by every module of the block; depends on nothing.
package lcdf_pkg;

   // Default line length, before the cursor wraps to the next row
   localparam int LINE_COLUMNS_DEF = 16;
   // Number of jobs held between the front and the back part
   localparam int QUEUE_DEPTH = 2;

   // Operation codes of an input item
   localparam logic OP_PRINT = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Serial framing bytes and display commands
   localparam logic [7:0] SYNC_COMMAND     = 8'hF8;
   localparam logic [7:0] SYNC_DATA        = 8'hFA;
   localparam logic [7:0] NIBBLE_MASK      = 8'hF0;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h30;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;

   // Special character codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Frame slots within one job
   localparam logic [1:0] FRAME_SETUP   = 2'd0;
   localparam logic [1:0] FRAME_ADDRESS = 2'd1;
   localparam logic [1:0] FRAME_DATA    = 2'd2;

   // Byte slots within one frame
   localparam logic [1:0] BYTE_SYNC = 2'd0;
   localparam logic [1:0] BYTE_HIGH = 2'd1;
   localparam logic [1:0] BYTE_LOW  = 2'd2;

   typedef enum logic [1:0] {
      JOB_CLEAR,
      JOB_NEWLINE,
      JOB_CHAR
   } job_kind_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] serial_byte;
      logic       frame_end;
      logic       last;
   } rsp_type;

   // One classified job handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   address;
      logic [7:0]   char_code;
   } job_type;

   // DDRAM base address of each display row
   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'h90;
         2'd2:    base = 8'h88;
         default: base = 8'h98;
      endcase
      return base;
   endfunction

endpackage

[rtl/core/lcdf_front.sv]
// Front part: accepts input items, tracks the text cursor and classifies
// each item into a job for the queue. Depends on lcdf_pkg.
module lcdf_front
   import lcdf_pkg::*;
#(
   parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    push_valid,
   output job_type push_job
);

   logic [1:0] row_ff, row_in;
   logic [4:0] column_ff, column_in;
   logic       accept;
   logic       wrap;
   logic [1:0] row_next;
   logic [1:0] char_row;
   logic [4:0] char_column;

   // Hold the requester while the queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Wrap a full line before printing
   assign wrap        = column_ff >= 5'(LINE_COLUMNS);
   assign row_next    = row_ff + 2'd1;
   assign char_row    = wrap ? row_next : row_ff;
   assign char_column = wrap ? 5'd0 : column_ff;

   // Classify the transfer and advance the cursor
   always_comb begin
      row_in             = row_ff;
      column_in          = column_ff;
      push_valid         = 1'b0;
      push_job.kind      = JOB_CLEAR;
      push_job.address   = row_base(char_row) + {3'b000, char_column};
      push_job.char_code = req_payload.char_code;
      if (accept) begin
         if (req_payload.operation == OP_CLEAR) begin
            push_valid    = 1'b1;
            push_job.kind = JOB_CLEAR;
            row_in        = 2'd0;
            column_in     = 5'd0;
         end else if (req_payload.char_code == CHAR_NUL) begin
            // drop string terminators
            push_valid = 1'b0;
         end else if (req_payload.char_code == CHAR_NEWLINE) begin
            push_valid       = 1'b1;
            push_job.kind    = JOB_NEWLINE;
            push_job.address = row_base(row_next);
            row_in           = row_next;
            column_in        = 5'd0;
         end else begin
            push_valid    = 1'b1;
            push_job.kind = JOB_CHAR;
            row_in        = char_row;
            column_in     = char_column + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= 2'd0;
         column_ff <= 5'd0;
      end else begin
         row_ff    <= row_in;
         column_ff <= column_in;
      end
   end

endmodule

[rtl/core/lcdf_queue.sv]
// Short job queue between the front and back parts of the framer.
// Depends on lcdf_pkg for the job type.
module lcdf_queue
   import lcdf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/lcdf_back.sv]
// Back part: expands a queued job into serial frames, one byte per cycle
// unless stalled, into a registered result stage. Depends on lcdf_pkg.
module lcdf_back
   import lcdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   input  job_type pop_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic       active_ff, active_in;
   job_type    job_ff, job_in;
   logic [1:0] frame_ff, frame_in;
   logic [1:0] byte_ff, byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       out_free;
   logic       emit;
   logic       done;
   logic [7:0] sync;
   logic [7:0] payload;
   logic [1:0] last_frame;
   rsp_type    cur_byte;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Select the sync byte and payload of the current frame
   always_comb begin
      case (frame_ff)
         FRAME_SETUP: begin
            sync    = SYNC_COMMAND;
            payload = (job_ff.kind == JOB_CLEAR) ? CMD_CLEAR : CMD_FUNCTION_SET;
         end
         FRAME_ADDRESS: begin
            sync    = SYNC_COMMAND;
            payload = job_ff.address;
         end
         default: begin
            sync    = SYNC_DATA;
            payload = job_ff.char_code;
         end
      endcase
   end

   // Find the final frame of the job
   always_comb begin
      case (job_ff.kind)
         JOB_CLEAR:   last_frame = FRAME_SETUP;
         JOB_NEWLINE: last_frame = FRAME_ADDRESS;
         default:     last_frame = FRAME_DATA;
      endcase
   end

   // Build the current byte
   always_comb begin
      case (byte_ff)
         BYTE_SYNC: cur_byte.serial_byte = sync;
         BYTE_HIGH: cur_byte.serial_byte = payload & NIBBLE_MASK;
         default:   cur_byte.serial_byte = {payload[3:0], 4'b0000};
      endcase
      cur_byte.frame_end = byte_ff == BYTE_LOW;
      cur_byte.last      = (byte_ff == BYTE_LOW) && (frame_ff == last_frame);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign done     = emit && cur_byte.last;
   assign pop      = pop_valid && (!active_ff || done);

   // Advance the byte sequencer and load the next job
   always_comb begin
      active_in = active_ff;
      job_in    = job_ff;
      frame_in  = frame_ff;
      byte_in   = byte_ff;
      if (pop) begin
         active_in = 1'b1;
         job_in    = pop_job;
         frame_in  = FRAME_SETUP;
         byte_in   = BYTE_SYNC;
      end else if (done) begin
         active_in = 1'b0;
      end else if (emit) begin
         if (byte_ff == BYTE_LOW) begin
            byte_in  = BYTE_SYNC;
            frame_in = frame_ff + 2'd1;
         end else begin
            byte_in = byte_ff + 2'd1;
         end
      end
   end

   // Hold the result register until its transfer
   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = cur_byte;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frame_ff     <= FRAME_SETUP;
         byte_ff      <= BYTE_SYNC;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         frame_ff     <= frame_in;
         byte_ff      <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/core/text_lcd_serial_cursor_framer_core.sv]
// Serial framer for a 4-row character LCD with a text cursor.
// An item passes the job queue and the job register; its bytes are offered
// from the result register. Throughput: one byte per cycle from the sequencer,
// unless stalled; a character is 9 bytes, a newline 6, a clear 3, a NUL none.
// A 2-entry job queue lets the input run ahead of the byte stream.
// Reset (synchronous) homes the cursor and empties the queue and output stage.
module text_lcd_serial_cursor_framer_core
   import lcdf_pkg::*;
#(
   parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   job_type pop_job;

   lcdf_front #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   lcdf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   lcdf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[dv/text_lcd_serial_cursor_framer_core_tb.sv]
// Testbench for the serial LCD cursor framer: directed and random text streams.
// A cursor predictor builds the expected byte frames; depends on lcdf_pkg and the core.
`timescale 1ns / 1ps

module text_lcd_serial_cursor_framer_core_tb;
   import lcdf_pkg::*;

   localparam int LINE_COLUMNS = LINE_COLUMNS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 100;

   // DDRAM base of each display row
   localparam logic [7:0] DDRAM_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Cursor state of the predictor
   logic [1:0] cursor_row;
   logic [4:0] cursor_col;

   rsp_type expected_bytes [$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      idle_on = 1'b0;
   int      stall_left = 0;
   int      free_left = 0;

   text_lcd_serial_cursor_framer_core #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none while idling is off
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Expected bytes of one transfer, cursor advanced as the display would
   function automatic void predict_frames(input req_type item);
      rsp_type    frames [9];
      logic [7:0] sync [3];
      logic [7:0] body [3];
      int         n_frames;
      int         n_bytes;
      logic [7:0] addr;
      n_frames = 0;
      if (item.operation == OP_CLEAR) begin
         sync[0] = SYNC_COMMAND;
         body[0] = CMD_CLEAR;
         n_frames = 1;
         cursor_row = '0;
         cursor_col = '0;
      end else if (item.char_code != CHAR_NUL) begin
         if (item.char_code == CHAR_NEWLINE) begin
            cursor_row = cursor_row + 2'd1;
            cursor_col = '0;
         end else if (cursor_col >= LINE_COLUMNS) begin
            cursor_row = cursor_row + 2'd1;
            cursor_col = '0;
         end
         addr = DDRAM_BASE[cursor_row] + {3'b000, cursor_col};
         sync[0] = SYNC_COMMAND;
         body[0] = CMD_FUNCTION_SET;
         sync[1] = SYNC_COMMAND;
         body[1] = addr;
         n_frames = 2;
         if (item.char_code != CHAR_NEWLINE) begin
            sync[2] = SYNC_DATA;
            body[2] = item.char_code;
            n_frames = 3;
            cursor_col = cursor_col + 5'd1;
         end
      end
      // split each frame into sync, high nibble, low nibble moved up
      n_bytes = 0;
      for (int f = 0; f < n_frames; f++) begin
         frames[n_bytes]     = '{serial_byte: sync[f], frame_end: 1'b0, last: 1'b0};
         frames[n_bytes + 1] = '{serial_byte: {body[f][7:4], 4'h0}, frame_end: 1'b0,
                                 last: 1'b0};
         frames[n_bytes + 2] = '{serial_byte: {body[f][3:0], 4'h0}, frame_end: 1'b1,
                                 last: 1'b0};
         n_bytes += 3;
      end
      if (n_bytes > 0) frames[n_bytes - 1].last = 1'b1;
      for (int b = 0; b < n_bytes; b++) expected_bytes.push_back(frames[b]);
   endfunction

   // Send one item; return at the edge of its transfer
   task automatic send_item(input logic op, input logic [7:0] code);
      int     gap;
      req_type item;
      gap = pick_gap();
      item.operation = op;
      item.char_code = code;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frames(item);
   endtask

   // Hold off the result side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 4);
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest expected byte
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %h/%b/%b", $time,
                     rsp_payload.serial_byte, rsp_payload.frame_end, rsp_payload.last);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.serial_byte !== want.serial_byte) begin
               $display("%0t: serial_byte mismatch: expected %h, actual %h", $time,
                        want.serial_byte, rsp_payload.serial_byte);
               error_count++;
            end
            if (rsp_payload.frame_end !== want.frame_end) begin
               $display("%0t: frame_end mismatch: expected %b, actual %b", $time,
                        want.frame_end, rsp_payload.frame_end);
               error_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $display("%0t: last mismatch: expected %b, actual %b", $time,
                        want.last, rsp_payload.last);
               error_count++;
            end
         end
      end
   end

   // Clear, printing, terminator and newline, back to back
   task automatic test_print_and_clear();
      idle_on = 1'b0;
      send_item(OP_CLEAR, 8'hFF);
      send_item(OP_PRINT, 8'h41);
      send_item(OP_PRINT, 8'hFF);
      send_item(OP_PRINT, 8'h01);
      send_item(OP_PRINT, CHAR_NUL);
      send_item(OP_PRINT, CHAR_NEWLINE);
      send_item(OP_CLEAR, 8'h00);
   endtask

   // Walk to the bottom row, fill it, and wrap back to the top row
   task automatic test_row_wrap();
      idle_on = 1'b1;
      repeat (3) send_item(OP_PRINT, CHAR_NEWLINE);
      for (int i = 0; i <= LINE_COLUMNS; i++) send_item(OP_PRINT, 8'h30 + i[7:0]);
   endtask

   // Random text with newlines, clears and ignored terminators
   task automatic test_random_text();
      int sent;
      int r;
      sent = 0;
      idle_on = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            sent++;
         end else if (r < 10) begin
            send_item(OP_PRINT, CHAR_NEWLINE);
            sent++;
         end else if (r < 14) begin
            send_item(OP_PRINT, CHAR_NUL);
         end else begin
            send_item(OP_PRINT, 8'($urandom_range(1, 255)));
            sent++;
         end
         // drop to back-to-back traffic for a stretch now and then
         if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      end
   endtask

   initial begin
      cursor_row = '0;
      cursor_col = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_print_and_clear();
      test_row_wrap();
      test_random_text();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
